FILE: rtl/irc_pkg.sv
// shared types, codes and constants of the interrupt redirection controller
package irc_pkg;

  localparam int unsigned CMD_W   = 2;
  localparam int unsigned OFF_W   = 12;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned PNUM_W  = 5;
  localparam int unsigned VEC_W   = 8;
  localparam int unsigned DEST_W  = 4;

  localparam int unsigned MAX_RESULTS = 24;
  localparam int unsigned CNT_W       = $clog2(MAX_RESULTS + 1);

  typedef enum logic [CMD_W-1:0] {
    CMD_READ  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_PIN   = 2'd2,
    CMD_EOI   = 2'd3
  } cmd_e;

  // register offsets in the bus region
  localparam logic [OFF_W-1:0] INDEX_OFFSET  = 12'h000;
  localparam logic [OFF_W-1:0] WINDOW_OFFSET = 12'h010;

  // window indices
  localparam logic [7:0] IDX_ID     = 8'h00;
  localparam logic [7:0] IDX_VER    = 8'h01;
  localparam logic [7:0] IDX_ARB    = 8'h02;
  localparam logic [7:0] ENTRY_BASE = 8'h10;

  localparam logic [DATA_W-1:0] VERSION_WORD = 32'h0011_0011;

  // delivery modes that never deliver
  localparam logic [2:0] DM_SMI    = 3'd2;
  localparam logic [2:0] DM_NMI    = 3'd4;
  localparam logic [2:0] DM_INIT   = 3'd5;
  localparam logic [2:0] DM_EXTINT = 3'd7;

  typedef struct packed {
    logic [DEST_W-1:0] dest;
    logic              mask;
    logic              trigger;
    logic              polarity;
    logic              dmode;
    logic [2:0]        delivery;
    logic [VEC_W-1:0]  vector;
  } entry_t;

  localparam entry_t ENTRY_RESET = entry_t'(19'h04000);

  typedef struct packed {
    logic              kind;
    logic [DATA_W-1:0] read_data;
    logic [DEST_W-1:0] dest_id;
    logic              logical_mode;
    logic [VEC_W-1:0]  irq_vector;
    logic              level_triggered;
    logic              last;
  } res_t;

  function automatic logic can_deliver(entry_t e);
    logic bad_mode;
    bad_mode = (e.delivery == DM_SMI) || (e.delivery == DM_NMI) ||
               (e.delivery == DM_INIT) || (e.delivery == DM_EXTINT);
    return !e.mask && !bad_mode;
  endfunction

  function automatic res_t delivery_res(entry_t e);
    res_t r;
    r.kind            = 1'b1;
    r.read_data       = '0;
    r.dest_id         = e.dest;
    r.logical_mode    = e.dmode;
    r.irq_vector      = e.vector;
    r.level_triggered = e.trigger;
    r.last            = 1'b0;
    return r;
  endfunction

endpackage

FILE: rtl/irc_in_if.sv
// input channel: command words into the controller
interface irc_in_if;
  logic                        valid;
  logic                        ready;
  logic [irc_pkg::CMD_W-1:0]   cmd;
  logic [irc_pkg::OFF_W-1:0]   offset;
  logic [irc_pkg::DATA_W-1:0]  write_data;
  logic [irc_pkg::PNUM_W-1:0]  pin_number;
  logic                        line_level;
  logic [irc_pkg::VEC_W-1:0]   eoi_vector;

  modport source (output valid, cmd, offset, write_data, pin_number, line_level, eoi_vector,
                  input ready);
  modport sink (input valid, cmd, offset, write_data, pin_number, line_level, eoi_vector,
                output ready);
endinterface

FILE: rtl/irc_out_if.sv
// output channel: read data and interrupt delivery words
interface irc_out_if;
  logic                        valid;
  logic                        ready;
  logic                        kind;
  logic [irc_pkg::DATA_W-1:0]  read_data;
  logic [irc_pkg::DEST_W-1:0]  dest_id;
  logic                        logical_mode;
  logic [irc_pkg::VEC_W-1:0]   irq_vector;
  logic                        level_triggered;
  logic                        last;

  modport source (output valid, kind, read_data, dest_id, logical_mode, irq_vector,
                  level_triggered, last, input ready);
  modport sink (input valid, kind, read_data, dest_id, logical_mode, irq_vector,
                level_triggered, last, output ready);
endinterface

FILE: rtl/interrupt_redirection_controller.sv
// interrupt redirection controller top level: register window, pin events, eoi scan
//
// usage:
//   in_i  takes command words: register read, register write, pin level event,
//         end of interrupt. a word is taken when valid and ready are both high.
//   out_o returns read data words and interrupt delivery words; the final word
//         caused by a command carries last.
//   a read, write or pin event does the redirection table memory read, then
//   evaluates, and a write stores the entry back. an eoi scan walks the
//   table one pin a cycle through the memory read port while the output
//   can take words, then flushes the held delivery word.
//   one command is in work at a time; ready is high only in idle.
//   a finished word sits in the output register; a new command is taken while
//   it waits, and the block stalls only when it must place another word.
//   reset clears the index, chip id, remote-irr and line bits and the per-pin
//   valid bits; an unwritten table entry reads as masked with all else zero.
//   at most 24 words are returned per command; further deliveries still
//   update remote-irr.
module interrupt_redirection_controller #(
  parameter int unsigned PINS = 24
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  irc_in_if.sink    in_i,
  irc_out_if.source out_o
);

  localparam int unsigned PIN_W      = (PINS > 1) ? $clog2(PINS) : 1;
  localparam int unsigned ENTRY_LAST = 16 + 2 * PINS - 1;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_EXEC  = 4'b0010,
    ST_SCAN  = 4'b0100,
    ST_FLUSH = 4'b1000
  } state_e;

  // control state
  state_e                         state_q, state_d;
  logic [7:0]                     idx_q, idx_d;
  logic [irc_pkg::DEST_W-1:0]     chip_q, chip_d;
  logic [PINS-1:0]                irr_q, irr_d;
  logic [PINS-1:0]                line_q, line_d;
  logic [PINS-1:0]                ent_vld_q, ent_vld_d;
  logic                           rd_vld_q;
  logic                           out_vld_q, out_vld_d;
  logic                           pend_vld_q, pend_vld_d;
  logic [irc_pkg::CNT_W-1:0]      count_q, count_d;
  logic [PIN_W-1:0]               cur_q, cur_d;

  // payload registers
  irc_pkg::cmd_e                  cmd_q;
  logic [irc_pkg::OFF_W-1:0]      off_q;
  logic [irc_pkg::DATA_W-1:0]     wd_q;
  logic                           lvl_q;
  logic                           pin_ok_q;
  logic [irc_pkg::VEC_W-1:0]      vec_q;
  irc_pkg::res_t                  out_res_q, out_res_d;
  irc_pkg::res_t                  pend_res_q, pend_res_d;

  // redirection table memory
  irc_pkg::entry_t                mem_q [PINS];
  irc_pkg::entry_t                rd_q;
  logic                           mem_we;
  logic                           mem_re;
  logic [PIN_W-1:0]               mem_raddr;
  irc_pkg::entry_t                mem_wdata;

  logic                           accept;
  logic                           out_free;
  irc_pkg::entry_t                ent;
  logic [7:0]                     idx_off;
  logic                           idx_entry;
  logic [PIN_W-1:0]               idx_pin;
  logic                           in_pin_ok;
  logic                           win_sel;

  assign accept    = in_i.valid && in_i.ready;
  assign out_free  = !out_vld_q || out_o.ready;
  // an entry never written reads as its reset value
  assign ent       = rd_vld_q ? rd_q : irc_pkg::ENTRY_RESET;
  assign idx_off   = idx_q - irc_pkg::ENTRY_BASE;
  assign idx_entry = (idx_q >= irc_pkg::ENTRY_BASE) && ({1'b0, idx_q} <= 9'(ENTRY_LAST));
  assign idx_pin   = idx_off[PIN_W:1];
  assign in_pin_ok = ({3'b000, in_i.pin_number} < 8'(PINS));
  assign win_sel   = (off_q == irc_pkg::WINDOW_OFFSET);

  assign in_i.ready = (state_q == ST_IDLE);

  always_comb begin
    irc_pkg::entry_t new_ent;
    irc_pkg::res_t   res;
    logic            emit;
    logic            fire;
    logic            asserted;
    logic            match;
    logic            cap_ok;
    logic            need_out;

    state_d    = state_q;
    idx_d      = idx_q;
    chip_d     = chip_q;
    irr_d      = irr_q;
    line_d     = line_q;
    ent_vld_d  = ent_vld_q;
    pend_vld_d = pend_vld_q;
    pend_res_d = pend_res_q;
    count_d    = count_q;
    cur_d      = cur_q;
    mem_we     = 1'b0;
    mem_re     = 1'b0;
    mem_raddr  = '0;
    mem_wdata  = ent;
    out_res_d  = out_res_q;
    out_vld_d  = out_vld_q && !out_o.ready;

    new_ent  = ent;
    res      = irc_pkg::delivery_res(ent);
    emit     = 1'b0;
    fire     = 1'b0;
    asserted = 1'b0;
    match    = 1'b0;
    cap_ok   = (count_q < irc_pkg::CNT_W'(irc_pkg::MAX_RESULTS));
    need_out = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          // issue the table read for whatever entry the command touches
          case (irc_pkg::cmd_e'(in_i.cmd)) inside
            irc_pkg::CMD_READ, irc_pkg::CMD_WRITE: begin
              mem_raddr = idx_pin;
              mem_re    = (in_i.offset == irc_pkg::WINDOW_OFFSET) && idx_entry;
              state_d   = ST_EXEC;
            end
            irc_pkg::CMD_PIN: begin
              mem_raddr = PIN_W'(in_i.pin_number);
              mem_re    = in_pin_ok;
              state_d   = ST_EXEC;
            end
            default: begin
              mem_raddr = '0;
              mem_re    = 1'b1;
              count_d   = '0;
              state_d   = ST_SCAN;
            end
          endcase
          cur_d = mem_raddr;
        end
      end

      ST_EXEC: begin
        case (cmd_q)
          irc_pkg::CMD_READ: begin
            res      = '0;
            res.last = 1'b1;
            if (off_q == irc_pkg::INDEX_OFFSET) begin
              res.read_data = {24'b0, idx_q};
            end else if (win_sel) begin
              if (idx_q == irc_pkg::IDX_ID || idx_q == irc_pkg::IDX_ARB) begin
                res.read_data = {4'b0, chip_q, 24'b0};
              end else if (idx_q == irc_pkg::IDX_VER) begin
                res.read_data = irc_pkg::VERSION_WORD;
              end else if (idx_entry) begin
                if (!idx_q[0]) begin
                  res.read_data = {15'b0, ent.mask, ent.trigger, irr_q[cur_q], ent.polarity,
                                   1'b0, ent.dmode, ent.delivery, ent.vector};
                end else begin
                  res.read_data = {4'b0, ent.dest, 24'b0};
                end
              end
            end
            emit = 1'b1;
          end
          irc_pkg::CMD_WRITE: begin
            if (win_sel && idx_entry) begin
              if (!idx_q[0]) begin
                new_ent.vector   = wd_q[7:0];
                new_ent.delivery = wd_q[10:8];
                new_ent.dmode    = wd_q[11];
                new_ent.polarity = wd_q[13];
                new_ent.trigger  = wd_q[15];
                new_ent.mask     = wd_q[16];
              end else begin
                new_ent.dest = wd_q[27:24];
              end
              // reassess the pin against the new entry
              fire = new_ent.trigger && line_q[cur_q] && !irr_q[cur_q] &&
                     irc_pkg::can_deliver(new_ent);
            end
            res      = irc_pkg::delivery_res(new_ent);
            res.last = 1'b1;
            emit     = fire;
          end
          irc_pkg::CMD_PIN: begin
            asserted = ent.polarity ? !lvl_q : lvl_q;
            if (pin_ok_q && asserted) begin
              fire = irc_pkg::can_deliver(ent) && (!ent.trigger || !irr_q[cur_q]);
            end
            res.last = 1'b1;
            emit     = fire;
          end
          default: ;
        endcase

        if (!emit || out_free) begin
          state_d = ST_IDLE;
          if (emit) begin
            out_vld_d = 1'b1;
            out_res_d = res;
          end
          case (cmd_q)
            irc_pkg::CMD_WRITE: begin
              if (off_q == irc_pkg::INDEX_OFFSET) begin
                idx_d = wd_q[7:0];
              end else if (win_sel && idx_q == irc_pkg::IDX_ID) begin
                chip_d = wd_q[27:24];
              end else if (win_sel && idx_entry) begin
                mem_we           = 1'b1;
                mem_wdata        = new_ent;
                ent_vld_d[cur_q] = 1'b1;
                if (fire) irr_d[cur_q] = 1'b1;
              end
            end
            irc_pkg::CMD_PIN: begin
              if (pin_ok_q) begin
                line_d[cur_q] = asserted;
                if (fire && ent.trigger) irr_d[cur_q] = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end

      ST_SCAN: begin
        // one pin a cycle unless output stalls; the newest delivery awaits its last flag
        match    = irr_q[cur_q] && (ent.vector == vec_q);
        fire     = match && line_q[cur_q] && ent.trigger && irc_pkg::can_deliver(ent);
        need_out = fire && cap_ok && pend_vld_q;
        if (!need_out || out_free) begin
          if (match) irr_d[cur_q] = fire;
          if (fire && cap_ok) begin
            if (pend_vld_q) begin
              out_vld_d = 1'b1;
              out_res_d = pend_res_q;
            end
            pend_vld_d = 1'b1;
            pend_res_d = irc_pkg::delivery_res(ent);
            count_d    = count_q + irc_pkg::CNT_W'(1);
          end
          if (cur_q == PIN_W'(PINS - 1)) begin
            state_d = ST_FLUSH;
          end else begin
            mem_re    = 1'b1;
            mem_raddr = cur_q + PIN_W'(1);
            cur_d     = mem_raddr;
          end
        end
      end

      ST_FLUSH: begin
        if (!pend_vld_q) begin
          state_d = ST_IDLE;
        end else if (out_free) begin
          out_vld_d      = 1'b1;
          out_res_d      = pend_res_q;
          out_res_d.last = 1'b1;
          pend_vld_d     = 1'b0;
          state_d        = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      idx_q      <= '0;
      chip_q     <= '0;
      irr_q      <= '0;
      line_q     <= '0;
      ent_vld_q  <= '0;
      rd_vld_q   <= 1'b0;
      out_vld_q  <= 1'b0;
      pend_vld_q <= 1'b0;
      count_q    <= '0;
      cur_q      <= '0;
    end else begin
      state_q    <= state_d;
      idx_q      <= idx_d;
      chip_q     <= chip_d;
      irr_q      <= irr_d;
      line_q     <= line_d;
      ent_vld_q  <= ent_vld_d;
      out_vld_q  <= out_vld_d;
      pend_vld_q <= pend_vld_d;
      count_q    <= count_d;
      cur_q      <= cur_d;
      if (mem_re) rd_vld_q <= ent_vld_q[mem_raddr];
    end
  end

  // command word capture and result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q    <= irc_pkg::cmd_e'(in_i.cmd);
      off_q    <= in_i.offset;
      wd_q     <= in_i.write_data;
      lvl_q    <= in_i.line_level;
      pin_ok_q <= in_pin_ok;
      vec_q    <= in_i.eoi_vector;
    end
    out_res_q  <= out_res_d;
    pend_res_q <= pend_res_d;
  end

  // table memory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[cur_q] <= mem_wdata;
    if (mem_re) rd_q <= mem_q[mem_raddr];
  end

  assign out_o.valid           = out_vld_q;
  assign out_o.kind            = out_res_q.kind;
  assign out_o.read_data       = out_res_q.read_data;
  assign out_o.dest_id         = out_res_q.dest_id;
  assign out_o.logical_mode    = out_res_q.logical_mode;
  assign out_o.irq_vector      = out_res_q.irq_vector;
  assign out_o.level_triggered = out_res_q.level_triggered;
  assign out_o.last            = out_res_q.last;

endmodule

FILE: tb/tb.sv
`timescale 1ns / 1ps
// self-checking bench for the interrupt redirection controller: directed table, random words
module tb;
  import irc_pkg::*;

  localparam int PINS           = 24;
  localparam int RANDOM_WORDS   = 500;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = PINS + 10;

  // one command word as the sender sees it
  typedef struct packed {
    cmd_e              cmd;
    logic [OFF_W-1:0]  offset;
    logic [DATA_W-1:0] write_data;
    logic [PNUM_W-1:0] pin_number;
    logic              line_level;
    logic [VEC_W-1:0]  eoi_vector;
  } cmd_word_t;

  // directed row: a word, plus a typed-in read value where it is obvious
  typedef struct packed {
    cmd_word_t         word;
    logic              fixed;
    logic [DATA_W-1:0] fixed_read;
  } dir_row_t;

  logic clk_i;
  logic rst_ni;

  irc_in_if  in_if ();
  irc_out_if out_if ();

  interrupt_redirection_controller #(
    .PINS(PINS)
  ) u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  // shadow copy of the controller state
  logic [7:0]        shadow_index;
  logic [DEST_W-1:0] shadow_chip_id;
  entry_t            shadow_tab [PINS];
  logic              shadow_irr [PINS];
  logic              shadow_line [PINS];

  // read and delivery words still owed by the block, oldest first
  res_t owed_words [$];

  int errors;
  int words_sent;
  int idle_cycles;
  int src_quiet;
  int sink_quiet;
  int sink_stall;
  dir_row_t dir_rows [$];

  // clock, 8 ns period
  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // prediction of the controller
  // ---------------------------------------------------------------------------

  task automatic shadow_reset();
    int p;
    shadow_index   = '0;
    shadow_chip_id = '0;
    for (p = 0; p < PINS; p++) begin
      shadow_tab[p]  = ENTRY_RESET;
      shadow_irr[p]  = 1'b0;
      shadow_line[p] = 1'b0;
    end
  endtask

  // delivery of one pin; a level entry sets remote-irr even past the word cap
  task automatic shadow_fire(int p, inout int n);
    entry_t e;
    res_t   r;
    e = shadow_tab[p];
    if (e.mask) return;
    // smi, nmi, init and extint never reach the output
    if (e.delivery == DM_SMI || e.delivery == DM_NMI ||
        e.delivery == DM_INIT || e.delivery == DM_EXTINT) return;
    if (e.trigger) shadow_irr[p] = 1'b1;
    if (n >= MAX_RESULTS) return;
    r                 = '0;
    r.kind            = 1'b1;
    r.dest_id         = e.dest;
    r.logical_mode    = e.dmode;
    r.irq_vector      = e.vector;
    r.level_triggered = e.trigger;
    owed_words.push_back(r);
    n++;
  endtask

  // level pin with its line up and remote-irr clear fires again
  task automatic shadow_reassess(int p, inout int n);
    if (!shadow_tab[p].trigger || !shadow_line[p] || shadow_irr[p]) return;
    shadow_fire(p, n);
  endtask

  function automatic logic [DATA_W-1:0] shadow_window_read();
    logic [7:0] idx;
    entry_t     e;
    int         p;
    idx = shadow_index;
    if (idx == IDX_ID || idx == IDX_ARB) return {4'h0, shadow_chip_id, 24'h0};
    if (idx == IDX_VER) return VERSION_WORD;
    if (int'(idx) < int'(ENTRY_BASE) || int'(idx) > int'(ENTRY_BASE) + 2 * PINS - 1) return '0;
    p = (int'(idx) - int'(ENTRY_BASE)) >> 1;
    e = shadow_tab[p];
    if (!idx[0]) begin
      return DATA_W'({e.mask, e.trigger, shadow_irr[p], e.polarity, 1'b0, e.dmode,
                      e.delivery, e.vector});
    end
    return {4'h0, e.dest, 24'h0};
  endfunction

  task automatic shadow_window_write(logic [DATA_W-1:0] v, inout int n);
    logic [7:0] idx;
    entry_t     e;
    int         p;
    idx = shadow_index;
    if (idx == IDX_ID) begin
      shadow_chip_id = v[27:24];
      return;
    end
    if (idx == IDX_VER || idx == IDX_ARB) return;
    if (int'(idx) < int'(ENTRY_BASE) || int'(idx) > int'(ENTRY_BASE) + 2 * PINS - 1) return;
    p = (int'(idx) - int'(ENTRY_BASE)) >> 1;
    e = shadow_tab[p];
    if (!idx[0]) begin
      // low dword: everything but destination, remote-irr stays
      e.vector   = v[7:0];
      e.delivery = v[10:8];
      e.dmode    = v[11];
      e.polarity = v[13];
      e.trigger  = v[15];
      e.mask     = v[16];
    end else begin
      e.dest = v[27:24];
    end
    shadow_tab[p] = e;
    shadow_reassess(p, n);
  endtask

  // expected words of one accepted command word
  task automatic shadow_step(cmd_word_t w);
    int          n;
    int          i;
    logic        asserted;
    res_t        r;
    logic [DATA_W-1:0] v;
    n = 0;
    case (w.cmd)
      CMD_READ: begin
        v = '0;
        if (w.offset == INDEX_OFFSET) v = {24'h0, shadow_index};
        else if (w.offset == WINDOW_OFFSET) v = shadow_window_read();
        r           = '0;
        r.read_data = v;
        owed_words.push_back(r);
        n = 1;
      end
      CMD_WRITE: begin
        if (w.offset == INDEX_OFFSET) shadow_index = w.write_data[7:0];
        else if (w.offset == WINDOW_OFFSET) shadow_window_write(w.write_data, n);
      end
      CMD_PIN: begin
        if (int'(w.pin_number) < PINS) begin
          i        = int'(w.pin_number);
          asserted = shadow_tab[i].polarity ? ~w.line_level : w.line_level;
          shadow_line[i] = asserted;
          if (asserted) begin
            if (shadow_tab[i].trigger) shadow_reassess(i, n);
            else shadow_fire(i, n);
          end
        end
      end
      default: begin
        // eoi scan, lowest pin first
        for (i = 0; i < PINS; i++) begin
          if (!shadow_irr[i] || shadow_tab[i].vector != w.eoi_vector) continue;
          shadow_irr[i] = 1'b0;
          if (shadow_line[i]) shadow_reassess(i, n);
        end
      end
    endcase
    if (n > 0) owed_words[owed_words.size() - 1].last = 1'b1;
  endtask

  // ---------------------------------------------------------------------------
  // idling and stimulus helpers
  // ---------------------------------------------------------------------------

  // mostly short gaps, a few long ones, now and then a stretch with none
  function automatic int pick_gap(inout int quiet_left);
    int r;
    if (quiet_left > 0) begin
      quiet_left--;
      return 0;
    end
    if ($urandom_range(0, 49) == 0) begin
      quiet_left = $urandom_range(10, 40);
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 48);
  endfunction

  // small vector pool so eoi words hit several pins at once
  function automatic logic [VEC_W-1:0] pick_vec();
    if ($urandom_range(0, 99) < 85) return VEC_W'(8'h40 + $urandom_range(0, 3));
    return VEC_W'($urandom);
  endfunction

  // pins crowd on the low few so state builds up
  function automatic int pick_pin();
    if ($urandom_range(0, 9) < 6) return $urandom_range(0, 5);
    return $urandom_range(0, PINS - 1);
  endfunction

  // low redirection dword biased toward deliverable entries
  function automatic logic [DATA_W-1:0] rand_low_dword();
    logic [DATA_W-1:0] v;
    v       = $urandom;
    v[7:0]  = pick_vec();
    if ($urandom_range(0, 2) != 0) v[10:8] = 3'($urandom_range(0, 1));
    v[16]   = ($urandom_range(0, 3) == 0);
    return v;
  endfunction

  function automatic dir_row_t mk_row(cmd_e cmd, logic [OFF_W-1:0] off,
                                      logic [DATA_W-1:0] wd, logic [PNUM_W-1:0] pin,
                                      logic lvl, logic [VEC_W-1:0] vec,
                                      logic fixed, logic [DATA_W-1:0] fixed_read);
    dir_row_t r;
    r.word.cmd        = cmd;
    r.word.offset     = off;
    r.word.write_data = wd;
    r.word.pin_number = pin;
    r.word.line_level = lvl;
    r.word.eoi_vector = vec;
    r.fixed           = fixed;
    r.fixed_read      = fixed_read;
    return r;
  endfunction

  // send one word: optional gap, hold until taken, then book the expectation
  task automatic drive_word(cmd_word_t w, logic fixed, logic [DATA_W-1:0] fixed_read);
    int   gap;
    res_t r;
    gap = pick_gap(src_quiet);
    if (gap > 0) begin
      in_if.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_if.cmd        = w.cmd;
    in_if.offset     = w.offset;
    in_if.write_data = w.write_data;
    in_if.pin_number = w.pin_number;
    in_if.line_level = w.line_level;
    in_if.eoi_vector = w.eoi_vector;
    in_if.valid      = 1'b1;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    if (fixed) begin
      // typed-in read value, reads leave the shadow state alone
      r           = '0;
      r.read_data = fixed_read;
      r.last      = 1'b1;
      owed_words.push_back(r);
    end else begin
      shadow_step(w);
    end
    words_sent++;
    @(negedge clk_i);
  endtask

  // well-formed entry programming: index, low dword, index, high dword
  task automatic program_pin();
    cmd_word_t  w;
    logic [7:0] idx;
    idx = 8'(int'(ENTRY_BASE) + 2 * pick_pin());
    w   = cmd_word_t'({$urandom, $urandom});
    w.cmd = CMD_WRITE;
    w.offset = INDEX_OFFSET;
    w.write_data = $urandom;
    w.write_data[7:0] = idx;
    drive_word(w, 1'b0, '0);
    w.offset = WINDOW_OFFSET;
    w.write_data = rand_low_dword();
    drive_word(w, 1'b0, '0);
    // now and then the high half is left out
    if ($urandom_range(0, 7) == 0) return;
    w.offset = INDEX_OFFSET;
    w.write_data = $urandom;
    w.write_data[7:0] = idx + 8'd1;
    drive_word(w, 1'b0, '0);
    w.offset = WINDOW_OFFSET;
    w.write_data = $urandom;
    drive_word(w, 1'b0, '0);
  endtask

  // one loose word, every field random before the bias
  task automatic random_word();
    cmd_word_t w;
    int        r;
    int        r2;
    w.offset     = OFF_W'($urandom);
    w.write_data = $urandom;
    w.pin_number = PNUM_W'($urandom);
    w.line_level = 1'($urandom);
    w.eoi_vector = VEC_W'($urandom);
    r  = $urandom_range(0, 99);
    r2 = $urandom_range(0, 99);
    if (r < 35) begin
      w.cmd = CMD_PIN;
      if (r2 < 90) w.pin_number = PNUM_W'(pick_pin());
    end else if (r < 55) begin
      w.cmd = CMD_EOI;
      if (r2 < 80) w.eoi_vector = pick_vec();
    end else if (r < 70) begin
      w.cmd = CMD_READ;
      if (r2 < 70) w.offset = WINDOW_OFFSET;
      else if (r2 < 90) w.offset = INDEX_OFFSET;
    end else if (r < 85) begin
      w.cmd = CMD_WRITE;
      if (r2 < 90) w.offset = INDEX_OFFSET;
      if (r2 < 60) w.write_data[7:0] = 8'(int'(ENTRY_BASE) + $urandom_range(0, 2 * PINS - 1));
      else if (r2 < 80) w.write_data[7:0] = 8'($urandom_range(0, 3));
    end else begin
      w.cmd    = CMD_WRITE;
      w.offset = WINDOW_OFFSET;
      if (r2 < 50) w.write_data = rand_low_dword();
    end
    drive_word(w, 1'b0, '0);
  endtask

  // ---------------------------------------------------------------------------
  // output side: random back-pressure and the scoreboard
  // ---------------------------------------------------------------------------

  initial begin
    out_if.ready = 1'b0;
    sink_quiet   = 0;
    sink_stall   = 0;
    wait (rst_ni === 1'b1);
    forever begin
      @(negedge clk_i);
      if (sink_stall > 0) begin
        out_if.ready = 1'b0;
        sink_stall--;
      end else begin
        out_if.ready = 1'b1;
        sink_stall   = pick_gap(sink_quiet);
      end
    end
  end

  task automatic check_field(string name, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      errors++;
    end
  endtask

  // every taken output word is held against the oldest owed word
  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (owed_words.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual kind %0h data %0h vector %0h",
                 $time, out_if.kind, out_if.read_data, out_if.irq_vector);
        errors++;
      end else begin
        want = owed_words.pop_front();
        check_field("kind", 32'(want.kind), 32'(out_if.kind));
        check_field("read_data", want.read_data, out_if.read_data);
        check_field("dest_id", 32'(want.dest_id), 32'(out_if.dest_id));
        check_field("logical_mode", 32'(want.logical_mode), 32'(out_if.logical_mode));
        check_field("irq_vector", 32'(want.irq_vector), 32'(out_if.irq_vector));
        check_field("level_triggered", 32'(want.level_triggered), 32'(out_if.level_triggered));
        check_field("last", 32'(want.last), 32'(out_if.last));
      end
    end
  end

  // watchdog: too long with no word moving on either side
  initial begin
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("watchdog expired at %0t", $time);
    $display("interrupt_redirection_controller regression: fail");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------

  initial begin
    int i;
    bit held_once;
    bit held_twice;

    // inputs known from time zero while reset is held low
    rst_ni           = 1'b0;
    in_if.valid      = 1'b0;
    in_if.cmd        = CMD_READ;
    in_if.offset     = '0;
    in_if.write_data = '0;
    in_if.pin_number = '0;
    in_if.line_level = 1'b0;
    in_if.eoi_vector = '0;
    errors     = 0;
    words_sent = 0;
    src_quiet  = 0;
    held_once  = 1'b0;
    held_twice = 1'b0;
    shadow_reset();
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed table: reset values, read-only and unused registers, ignored
    // offsets and pins, then one level pin through assert, eoi and release
    dir_rows.push_back(mk_row(CMD_READ,  INDEX_OFFSET,  '0, '0, 1'b0, '0, 1'b1, 32'h0));
    dir_rows.push_back(mk_row(CMD_READ,  WINDOW_OFFSET, '0, '0, 1'b0, '0, 1'b1, 32'h0));
    dir_rows.push_back(mk_row(CMD_WRITE, INDEX_OFFSET,  32'h1, '0, 1'b0, '0, 1'b0, '0));
    dir_rows.push_back(mk_row(CMD_READ,  WINDOW_OFFSET, '0, '0, 1'b0, '0, 1'b1, VERSION_WORD));
    dir_rows.push_back(mk_row(CMD_WRITE, WINDOW_OFFSET, '1, '0, 1'b0, '0, 1'b0, '0));
    dir_rows.push_back(mk_row(CMD_READ,  WINDOW_OFFSET, '0, '0, 1'b0, '0, 1'b1, VERSION_WORD));
    dir_rows.push_back(mk_row(CMD_WRITE, INDEX_OFFSET,  32'h0, '0, 1'b0, '0, 1'b0, '0));
    dir_rows.push_back(mk_row(CMD_WRITE, WINDOW_OFFSET, '1, '0, 1'b0, '0, 1'b0, '0));
    dir_rows.push_back(mk_row(CMD_READ,  WINDOW_OFFSET, '0, '0, 1'b0, '0, 1'b1, 32'h0f00_0000));
    dir_rows.push_back(mk_row(CMD_WRITE, INDEX_OFFSET,  32'h2, '0, 1'b0, '0, 1'b0, '0));
    dir_rows.push_back(mk_row(CMD_WRITE, WINDOW_OFFSET, '0, '0, 1'b0, '0, 1'b0, '0));
    dir_rows.push_back(mk_row(CMD_READ,  WINDOW_OFFSET, '0, '0, 1'b0, '0, 1'b1, 32'h0f00_0000));
    // index keeps only its low byte
    dir_rows.push_back(mk_row(CMD_WRITE, INDEX_OFFSET,  32'hffff_ff10, '0, 1'b0, '0, 1'b0, '0));
    dir_rows.push_back(mk_row(CMD_READ,  INDEX_OFFSET,  '0, '0, 1'b0, '0, 1'b1, 32'h10));
    dir_rows.push_back(mk_row(CMD_READ,  WINDOW_OFFSET, '0, '0, 1'b0, '0, 1'b1, 32'h0001_0000));
    // offset outside both registers
    dir_rows.push_back(mk_row(CMD_WRITE, '1, '1, '1, 1'b1, '1, 1'b0, '0));
    dir_rows.push_back(mk_row(CMD_READ,  '1, '1, '1, 1'b1, '1, 1'b1, 32'h0));
    // window index past the last entry
    dir_rows.push_back(mk_row(CMD_WRITE, INDEX_OFFSET,  32'hff, '0, 1'b0, '0, 1'b0, '0));
    dir_rows.push_back(mk_row(CMD_WRITE, WINDOW_OFFSET, '1, '0, 1'b0, '0, 1'b0, '0));
    dir_rows.push_back(mk_row(CMD_READ,  WINDOW_OFFSET, '0, '0, 1'b0, '0, 1'b1, 32'h0));
    // pin beyond the last one
    dir_rows.push_back(mk_row(CMD_PIN,   '0, '0, 5'd31, 1'b1, '0, 1'b0, '0));
    // pin 0: level, active low, vector ff, unmasked; line still idle
    dir_rows.push_back(mk_row(CMD_WRITE, INDEX_OFFSET,  32'h10, '0, 1'b0, '0, 1'b0, '0));
    dir_rows.push_back(mk_row(CMD_WRITE, WINDOW_OFFSET, 32'h0000_a0ff, '0, 1'b0, '0, 1'b0, '0));
    dir_rows.push_back(mk_row(CMD_PIN,   '0, '0, 5'd0, 1'b0, '0, 1'b0, '0));
    dir_rows.push_back(mk_row(CMD_PIN,   '0, '0, 5'd0, 1'b0, '0, 1'b0, '0));
    dir_rows.push_back(mk_row(CMD_EOI,   '0, '0, '0, 1'b0, 8'hff, 1'b0, '0));
    dir_rows.push_back(mk_row(CMD_PIN,   '0, '0, 5'd0, 1'b1, '0, 1'b0, '0));

    for (i = 0; i < dir_rows.size(); i++) begin
      drive_word(dir_rows[i].word, dir_rows[i].fixed, dir_rows[i].fixed_read);
    end

    // random part: entry programming mixed with loose words
    while (words_sent < dir_rows.size() + RANDOM_WORDS) begin
      // sender holds off until the block has drained, twice
      if ((!held_once && words_sent >= dir_rows.size() + RANDOM_WORDS / 2) ||
          (!held_twice && words_sent >= dir_rows.size() + (RANDOM_WORDS * 4) / 5)) begin
        if (held_once) held_twice = 1'b1;
        held_once   = 1'b1;
        in_if.valid = 1'b0;
        wait (owed_words.size() == 0);
        @(negedge clk_i);
      end
      if ($urandom_range(0, 99) < 30) program_pin();
      else random_word();
    end
    in_if.valid = 1'b0;

    // drain, then keep watching to catch stray words
    wait (owed_words.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0) begin
      $display("interrupt_redirection_controller regression: pass");
    end else begin
      $display("interrupt_redirection_controller regression: fail");
    end
    $finish;
  end

endmodule
